FILE: src/ilsup_pkg.sv
// Shared types, codes and reset values for the ignition link supervisor.
// No dependencies; every other file in src imports this package.
package ilsup_pkg;

    // Default widths for the tick timers and the wrapping counters
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths of the ports
    localparam int CFG_W     = 16;
    localparam int TOPIC_W   = 11;
    localparam int LEN_W     = 4;
    localparam int ACTION_W  = 3;
    localparam int CODE_W    = 64;
    localparam int STAT_W    = 16;
    localparam int FLAGS_W   = 3;
    localparam int MODE_W    = 2;
    localparam int KIND_W    = 2;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    // Register reset values
    localparam logic [CFG_W-1:0]   POLL_INTERVAL_RST   = 16'd1000;
    localparam logic [CFG_W-1:0]   OFFLINE_TIMEOUT_RST = 16'd5000;
    localparam logic [CFG_W-1:0]   ABORT_MASK_RST      = 16'h0707;
    localparam logic [TOPIC_W-1:0] STATUS_TOPIC_RST    = 11'd0;
    localparam logic [LEN_W-1:0]   STATUS_LENGTH_RST   = 4'd2;

    // Register indexes (byte address is four times the index)
    typedef enum logic [REG_IDX_W-1:0] {
        REG_POLL_INTERVAL   = 3'd0,
        REG_OFFLINE_TIMEOUT = 3'd1,
        REG_ABORT_MASK      = 3'd2,
        REG_STATUS_TOPIC    = 3'd3,
        REG_STATUS_LENGTH   = 3'd4
    } reg_idx_t;

    // Input actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK           = 3'd0,
        ACT_MESSAGE        = 3'd1,
        ACT_LIFTOFF        = 3'd2,
        ACT_CMD_ABORT      = 3'd3,
        ACT_GROUND_OFFLINE = 3'd4,
        ACT_LAUNCH         = 3'd5
    } action_t;

    // Outgoing command kinds
    typedef enum logic [KIND_W-1:0] {
        SEND_NONE       = 2'd0,
        SEND_STATUS_REQ = 2'd1,
        SEND_ABORT      = 2'd2,
        SEND_LAUNCH     = 2'd3
    } send_kind_t;

    // Supervisor mode, one-hot internally
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_ABORTED = 3'b010,
        MODE_END     = 3'b100
    } mode_t;

    // Mode codes as reported on the result word
    localparam logic [MODE_W-1:0] MODE_OUT_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OUT_ABORTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT_END     = 2'd2;

    // Sticky flag bits
    localparam int FLAG_ABORT_SENT   = 0;
    localparam int FLAG_LAUNCH_SENT  = 1;
    localparam int FLAG_ABORT_RECVD  = 2;

    typedef struct packed {
        logic [CFG_W-1:0]   poll_interval;
        logic [CFG_W-1:0]   offline_timeout;
        logic [CFG_W-1:0]   abort_mask;
        logic [TOPIC_W-1:0] status_topic;
        logic [LEN_W-1:0]   status_length;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TOPIC_W-1:0]  msg_topic;
        logic [LEN_W-1:0]    msg_length;
        logic [CFG_W-1:0]    msg_status_word;
        logic [CODE_W-1:0]   launch_code;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  send_kind;
        logic [CODE_W-1:0]  send_payload;
        logic               offline_alarm;
        logic               aborted_alarm;
        logic [MODE_W-1:0]  mode;
        logic [STAT_W-1:0]  sent_total;
        logic [STAT_W-1:0]  received_total;
        logic [FLAGS_W-1:0] flags;
    } res_t;

endpackage

FILE: src/ilsup_regs.sv
// APB-style configuration register bank of the ignition link supervisor.
// Depends on ilsup_pkg for the register map, reset values and cfg_t.
module ilsup_regs import ilsup_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t reg_sel;

    // Zero-wait-state port
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_POLL_INTERVAL:   cfg_next.poll_interval   = pwdata[CFG_W-1:0];
                REG_OFFLINE_TIMEOUT: cfg_next.offline_timeout = pwdata[CFG_W-1:0];
                REG_ABORT_MASK:      cfg_next.abort_mask      = pwdata[CFG_W-1:0];
                REG_STATUS_TOPIC:    cfg_next.status_topic    = pwdata[TOPIC_W-1:0];
                REG_STATUS_LENGTH:   cfg_next.status_length   = pwdata[LEN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval   <= POLL_INTERVAL_RST;
            cfg_reg.offline_timeout <= OFFLINE_TIMEOUT_RST;
            cfg_reg.abort_mask      <= ABORT_MASK_RST;
            cfg_reg.status_topic    <= STATUS_TOPIC_RST;
            cfg_reg.status_length   <= STATUS_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            REG_POLL_INTERVAL:   prdata = PDATA_W'(cfg_reg.poll_interval);
            REG_OFFLINE_TIMEOUT: prdata = PDATA_W'(cfg_reg.offline_timeout);
            REG_ABORT_MASK:      prdata = PDATA_W'(cfg_reg.abort_mask);
            REG_STATUS_TOPIC:    prdata = PDATA_W'(cfg_reg.status_topic);
            REG_STATUS_LENGTH:   prdata = PDATA_W'(cfg_reg.status_length);
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/ilsup_core.sv
// Supervisor state and per-word step logic: mode, poll and offline timers,
// command and receive counters, sticky flags. Depends on ilsup_pkg.
module ilsup_core import ilsup_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    mode_t                  mode_reg,     mode_next;
    logic [TIMER_WIDTH-1:0] poll_cd_reg,  poll_cd_next;
    logic [TIMER_WIDTH-1:0] off_cd_reg,   off_cd_next;
    logic                   armed_reg,    armed_next;
    logic [COUNT_WIDTH-1:0] sent_reg,     sent_next;
    logic [COUNT_WIDTH-1:0] recvd_reg,    recvd_next;
    logic [FLAGS_W-1:0]     flags_reg,    flags_next;

    send_kind_t             kind;
    logic [CODE_W-1:0]      payload;
    logic                   off_alarm;
    logic                   ab_alarm;
    logic                   live;
    logic                   idle;
    logic                   msg_ok;
    logic [MODE_W-1:0]      mode_code;

    assign idle   = (mode_reg == MODE_IDLE);
    assign live   = idle || (mode_reg == MODE_ABORTED);
    assign msg_ok = (item.msg_topic == cfg.status_topic) &&
                    (item.msg_length == cfg.status_length);

    // Work out the effect of one word
    always_comb
    begin
        mode_next    = mode_reg;
        poll_cd_next = poll_cd_reg;
        off_cd_next  = off_cd_reg;
        armed_next   = armed_reg;
        sent_next    = sent_reg;
        recvd_next   = recvd_reg;
        flags_next   = flags_reg;
        kind         = SEND_NONE;
        payload      = '0;
        off_alarm    = 1'b0;
        ab_alarm     = 1'b0;

        if (live)
        begin
            case (action_t'(item.action))
                ACT_TICK:
                begin
                    // Poll timer: a countdown of one or zero fires
                    if (poll_cd_reg <= TIMER_WIDTH'(1))
                    begin
                        kind         = SEND_STATUS_REQ;
                        sent_next    = sent_reg + COUNT_WIDTH'(1);
                        poll_cd_next = TIMER_WIDTH'(cfg.poll_interval);
                    end
                    else
                    begin
                        poll_cd_next = poll_cd_reg - TIMER_WIDTH'(1);
                    end
                    // Offline timer fires once; a good message rearms it
                    if (armed_reg)
                    begin
                        if (off_cd_reg <= TIMER_WIDTH'(1))
                        begin
                            off_alarm  = 1'b1;
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            off_cd_next = off_cd_reg - TIMER_WIDTH'(1);
                        end
                    end
                end
                ACT_MESSAGE:
                begin
                    if (msg_ok)
                    begin
                        recvd_next  = recvd_reg + COUNT_WIDTH'(1);
                        off_cd_next = TIMER_WIDTH'(cfg.offline_timeout);
                        armed_next  = 1'b1;
                        // Board abort: latch, alarm and poll at once
                        if (idle && ((item.msg_status_word & cfg.abort_mask) != '0))
                        begin
                            flags_next[FLAG_ABORT_RECVD] = 1'b1;
                            mode_next    = MODE_ABORTED;
                            ab_alarm     = 1'b1;
                            kind         = SEND_STATUS_REQ;
                            sent_next    = sent_reg + COUNT_WIDTH'(1);
                            poll_cd_next = TIMER_WIDTH'(cfg.poll_interval);
                        end
                    end
                end
                ACT_LIFTOFF:
                begin
                    if (idle)
                    begin
                        mode_next = MODE_END;
                    end
                end
                ACT_CMD_ABORT, ACT_GROUND_OFFLINE:
                begin
                    if ((action_t'(item.action) == ACT_CMD_ABORT) || idle)
                    begin
                        kind      = SEND_ABORT;
                        sent_next = sent_reg + COUNT_WIDTH'(1);
                        flags_next[FLAG_ABORT_SENT] = 1'b1;
                    end
                end
                ACT_LAUNCH:
                begin
                    if (idle)
                    begin
                        kind      = SEND_LAUNCH;
                        payload   = item.launch_code;
                        sent_next = sent_reg + COUNT_WIDTH'(1);
                        flags_next[FLAG_LAUNCH_SENT] = 1'b1;
                    end
                end
                default:
                begin
                    kind = SEND_NONE;
                end
            endcase
        end
    end

    // Advance state only when the word moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            poll_cd_reg <= TIMER_WIDTH'(1);
            off_cd_reg  <= TIMER_WIDTH'(OFFLINE_TIMEOUT_RST);
            armed_reg   <= 1'b1;
            sent_reg    <= '0;
            recvd_reg   <= '0;
            flags_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            poll_cd_reg <= poll_cd_next;
            off_cd_reg  <= off_cd_next;
            armed_reg   <= armed_next;
            sent_reg    <= sent_next;
            recvd_reg   <= recvd_next;
            flags_reg   <= flags_next;
        end
    end

    // Map the one-hot mode to its reported code
    always_comb
    begin
        case (mode_next)
            MODE_IDLE:    mode_code = MODE_OUT_IDLE;
            MODE_ABORTED: mode_code = MODE_OUT_ABORTED;
            MODE_END:     mode_code = MODE_OUT_END;
            default:      mode_code = MODE_OUT_IDLE;
        endcase
    end

    // Assemble the result word
    always_comb
    begin
        res.send_kind      = kind;
        res.send_payload   = payload;
        res.offline_alarm  = off_alarm;
        res.aborted_alarm  = ab_alarm;
        res.mode           = mode_code;
        res.sent_total     = STAT_W'(sent_next);
        res.received_total = STAT_W'(recvd_next);
        res.flags          = flags_next;
    end

endmodule

FILE: src/ignition_link_supervisor_unit.sv
// Top level of the ignition link supervisor: input register, result register,
// handshakes and configuration port. Depends on ilsup_pkg, ilsup_regs, ilsup_core.
//
// The unit takes one word per clock while result_ready is high and gives one
// result word per input word. The word is captured in an input register, the
// supervisor state (mode, poll and offline timers, counters, flags) is updated
// in a single pass by ilsup_core, and the result lands in an output register;
// result_valid rises as the word moves from the input register into it.
// item_ready stays high while a result waits if the input register is empty,
// and full throughput is kept whenever result_ready is high.
// Registers are written over the APB-style port at byte address 4*index and
// should only be changed while no word is in flight. New poll_interval and
// offline_timeout values take effect at the next timer reload.
module ignition_link_supervisor_unit import ilsup_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // input word
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [TOPIC_W-1:0]  msg_topic,
    input  logic [LEN_W-1:0]    msg_length,
    input  logic [CFG_W-1:0]    msg_status_word,
    input  logic [CODE_W-1:0]   launch_code,
    // result word
    output logic                result_valid,
    input  logic                result_ready,
    output logic [KIND_W-1:0]   send_kind,
    output logic [CODE_W-1:0]   send_payload,
    output logic                offline_alarm,
    output logic                aborted_alarm,
    output logic [MODE_W-1:0]   mode,
    output logic [STAT_W-1:0]   sent_total,
    output logic [STAT_W-1:0]   received_total,
    output logic [FLAGS_W-1:0]  flags
);

    cfg_t  cfg;
    item_t item_reg;
    logic  item_valid_reg, item_valid_next;
    res_t  res;
    res_t  res_reg;
    logic  result_valid_reg, result_valid_next;
    logic  advance;
    logic  step;
    logic  take;

    ilsup_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: result register frees up, input register drains into it
    assign advance    = !result_valid_reg || result_ready;
    assign step       = item_valid_reg && advance;
    assign item_ready = !item_valid_reg || advance;
    assign take       = item_valid && item_ready;

    assign item_valid_next   = take || (item_valid_reg && !advance);
    assign result_valid_next = step || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.action          <= action;
            item_reg.msg_topic       <= msg_topic;
            item_reg.msg_length      <= msg_length;
            item_reg.msg_status_word <= msg_status_word;
            item_reg.launch_code     <= launch_code;
        end
    end

    ilsup_core #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign result_valid   = result_valid_reg;
    assign send_kind      = res_reg.send_kind;
    assign send_payload   = res_reg.send_payload;
    assign offline_alarm  = res_reg.offline_alarm;
    assign aborted_alarm  = res_reg.aborted_alarm;
    assign mode           = res_reg.mode;
    assign sent_total     = res_reg.sent_total;
    assign received_total = res_reg.received_total;
    assign flags          = res_reg.flags;

endmodule

FILE: src/ilsup_checker.sv
// Port-level checks for the ignition link supervisor, bound to the top level.
// Depends on ilsup_pkg and ignition_link_supervisor_unit.
module ilsup_checker import ilsup_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input logic [KIND_W-1:0]   send_kind,
    input logic [CODE_W-1:0]   send_payload,
    input logic                offline_alarm,
    input logic                aborted_alarm,
    input logic [MODE_W-1:0]   mode,
    input logic [FLAGS_W-1:0]  flags
);

    // Payload carries a code only with a launch command
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (send_kind == SEND_LAUNCH) || (send_payload == '0))
        else $error("payload set without launch command");

    // A board abort always polls, sets the received flag and enters aborted mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && aborted_alarm) |->
            (send_kind == SEND_STATUS_REQ) && (mode == MODE_OUT_ABORTED) &&
            flags[FLAG_ABORT_RECVD])
        else $error("aborted alarm without poll, mode or flag");

    // End mode is silent
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (mode == MODE_OUT_END)) |->
            (send_kind == SEND_NONE) && !offline_alarm && !aborted_alarm)
        else $error("activity reported in end mode");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            result_valid && $stable(send_kind) && $stable(mode) && $stable(flags))
        else $error("stalled result changed");

endmodule

bind ignition_link_supervisor_unit ilsup_checker u_ilsup_checker (.*);

FILE: tb/sv/ignition_link_supervisor_unit_tb.sv
// Self-checking testbench for ignition_link_supervisor_unit: directed and random words
// checked against an in-bench supervisor predictor. Depends on ilsup_pkg and the unit.
module ignition_link_supervisor_unit_tb;
    import ilsup_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Encodings the package leaves unnamed
    localparam logic [REG_IDX_W-1:0] REG_SPARE    = 3'd5;
    localparam logic [ACTION_W-1:0]  ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0]  ACT_SPARE_HI = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                item_valid;
    logic                item_ready;
    logic [ACTION_W-1:0] action;
    logic [TOPIC_W-1:0]  msg_topic;
    logic [LEN_W-1:0]    msg_length;
    logic [CFG_W-1:0]    msg_status_word;
    logic [CODE_W-1:0]   launch_code;
    logic                result_valid;
    logic                result_ready;
    logic [KIND_W-1:0]   send_kind;
    logic [CODE_W-1:0]   send_payload;
    logic                offline_alarm;
    logic                aborted_alarm;
    logic [MODE_W-1:0]   mode;
    logic [STAT_W-1:0]   sent_total;
    logic [STAT_W-1:0]   received_total;
    logic [FLAGS_W-1:0]  flags;

    // Predictor copy of the registers and the supervisor state
    logic [CFG_W-1:0]             cfg_poll;
    logic [CFG_W-1:0]             cfg_timeout;
    logic [CFG_W-1:0]             cfg_mask;
    logic [TOPIC_W-1:0]           cfg_topic;
    logic [LEN_W-1:0]             cfg_len;
    logic [MODE_W-1:0]            sup_mode;
    logic [TIMER_WIDTH_DEF-1:0]   poll_left;
    logic [TIMER_WIDTH_DEF-1:0]   off_left;
    logic                         off_armed;
    logic [COUNT_WIDTH_DEF-1:0]   sent_cnt;
    logic [COUNT_WIDTH_DEF-1:0]   recv_cnt;
    logic [FLAGS_W-1:0]           sticky;

    res_t report_q[$];
    res_t want;
    int   fault_count;
    int   cycle_count;
    int   ready_hold;
    bit   bursts_on;

    ignition_link_supervisor_unit i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the predicted state by one accepted word and return its report
    function automatic res_t predict_report(input logic [ACTION_W-1:0] act,
                                            input logic [TOPIC_W-1:0]  topic,
                                            input logic [LEN_W-1:0]    len,
                                            input logic [CFG_W-1:0]    word,
                                            input logic [CODE_W-1:0]   code);
        res_t r;
        logic in_idle;
        logic live;
        r = '0;
        in_idle = (sup_mode == MODE_OUT_IDLE);
        live = in_idle || (sup_mode == MODE_OUT_ABORTED);
        if (live)
        begin
            case (act)
                ACT_TICK:
                begin
                    if (poll_left <= 1)
                    begin
                        r.send_kind = SEND_STATUS_REQ;
                        sent_cnt++;
                        poll_left = cfg_poll;
                    end
                    else
                        poll_left--;
                    if (off_armed)
                    begin
                        if (off_left <= 1)
                        begin
                            r.offline_alarm = 1'b1;
                            off_armed = 1'b0;
                        end
                        else
                            off_left--;
                    end
                end
                ACT_MESSAGE:
                begin
                    if (topic == cfg_topic && len == cfg_len)
                    begin
                        recv_cnt++;
                        off_left = cfg_timeout;
                        off_armed = 1'b1;
                        // board abort: latch it, leave idle and poll at once
                        if (in_idle && (word & cfg_mask) != '0)
                        begin
                            sticky[FLAG_ABORT_RECVD] = 1'b1;
                            sup_mode = MODE_OUT_ABORTED;
                            r.aborted_alarm = 1'b1;
                            r.send_kind = SEND_STATUS_REQ;
                            sent_cnt++;
                            poll_left = cfg_poll;
                        end
                    end
                end
                ACT_LIFTOFF:
                begin
                    if (in_idle)
                        sup_mode = MODE_OUT_END;
                end
                ACT_CMD_ABORT, ACT_GROUND_OFFLINE:
                begin
                    if (act == ACT_CMD_ABORT || in_idle)
                    begin
                        r.send_kind = SEND_ABORT;
                        sent_cnt++;
                        sticky[FLAG_ABORT_SENT] = 1'b1;
                    end
                end
                ACT_LAUNCH:
                begin
                    if (in_idle)
                    begin
                        r.send_kind = SEND_LAUNCH;
                        r.send_payload = code;
                        sent_cnt++;
                        sticky[FLAG_LAUNCH_SENT] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.mode = sup_mode;
        r.sent_total = sent_cnt;
        r.received_total = recv_cnt;
        r.flags = sticky;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fault_count++;
        end
    endfunction

    // Offer one word, hold it until accepted, then record its prediction
    task automatic push_word(input logic [ACTION_W-1:0] act, input logic [TOPIC_W-1:0] topic,
                             input logic [LEN_W-1:0] len, input logic [CFG_W-1:0] word,
                             input logic [CODE_W-1:0] code);
        if (bursts_on && $urandom_range(3, 0) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        item_valid      <= 1'b1;
        action          <= act;
        msg_topic       <= topic;
        msg_length      <= len;
        msg_status_word <= word;
        launch_code     <= code;
        do
            @(posedge clk);
        while (!item_ready);
        report_q.push_back(predict_report(act, topic, len, word, code));
    endtask

    // Drop valid and wait out every pending result and the pipeline behind it
    task automatic settle_link();
        item_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access cycle, then one quiet cycle on the bus
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_POLL_INTERVAL:   cfg_poll    = value[CFG_W-1:0];
            REG_OFFLINE_TIMEOUT: cfg_timeout = value[CFG_W-1:0];
            REG_ABORT_MASK:      cfg_mask    = value[CFG_W-1:0];
            REG_STATUS_TOPIC:    cfg_topic   = value[TOPIC_W-1:0];
            REG_STATUS_LENGTH:   cfg_len     = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Random word, weighted toward ticks and well-formed status messages
    task automatic push_random_word(input bit allow_liftoff);
        logic [ACTION_W-1:0] act;
        logic [TOPIC_W-1:0]  topic;
        logic [LEN_W-1:0]    len;
        logic [CFG_W-1:0]    word;
        int pick;
        pick  = $urandom_range(99, 0);
        topic = TOPIC_W'($urandom);
        len   = LEN_W'($urandom_range(8, 0));
        word  = CFG_W'($urandom);
        if ($urandom_range(7, 0) == 0)
            len = LEN_W'($urandom);
        if (pick < 45)
            act = ACT_TICK;
        else if (pick < 75)
        begin
            act = ACT_MESSAGE;
            if (pick < 67)
            begin
                topic = cfg_topic;
                len   = cfg_len;
            end
            else if (pick < 71)
                topic = cfg_topic;
            else
                len = cfg_len;
        end
        else if (pick < 81)
            act = ACT_CMD_ABORT;
        else if (pick < 87)
            act = ACT_GROUND_OFFLINE;
        else if (pick < 93)
            act = ACT_LAUNCH;
        else if (pick < 97 || !allow_liftoff)
            act = ACTION_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        else
            act = ACT_LIFTOFF;
        // keep idle from tripping on a status word under the mask
        if (act == ACT_MESSAGE && sup_mode == MODE_OUT_IDLE && topic == cfg_topic &&
            len == cfg_len)
            word = word & ~cfg_mask;
        push_word(act, topic, len, word, {$urandom, $urandom});
    endtask

    task automatic test_power_on_polling();
        write_reg(REG_POLL_INTERVAL, '0);
        write_reg(REG_OFFLINE_TIMEOUT, '0);
        // first tick polls; a zero interval then polls on every tick
        push_word(ACT_TICK, '0, '0, '0, '0);
        push_word(ACT_TICK, '1, '1, '1, '1);
        // well-formed status with reset topic and length, clear of the reset mask
        push_word(ACT_MESSAGE, STATUS_TOPIC_RST, STATUS_LENGTH_RST, ~ABORT_MASK_RST, '0);
        // zero timeout: poll and offline alarm on the same tick, alarm once only
        push_word(ACT_TICK, '0, '0, '0, '0);
        push_word(ACT_TICK, '0, '0, '0, '0);
        // malformed messages carrying abort bits are dropped
        push_word(ACT_MESSAGE, STATUS_TOPIC_RST, LEN_W'(STATUS_LENGTH_RST + 1), '1, '0);
        push_word(ACT_MESSAGE, TOPIC_W'(STATUS_TOPIC_RST + 1), STATUS_LENGTH_RST, '1, '0);
        push_word(ACT_SPARE_LO, '1, '1, '1, '1);
        push_word(ACT_SPARE_HI, '0, '0, '0, '0);
    endtask

    task automatic test_command_requests();
        push_word(ACT_CMD_ABORT, '1, '1, '1, '1);
        push_word(ACT_GROUND_OFFLINE, '0, '0, '0, '0);
        push_word(ACT_LAUNCH, '0, '0, '0, '1);
        push_word(ACT_LAUNCH, '1, '1, '1, '0);
        push_word(ACT_LAUNCH, '0, 4'd8, '0, 64'hA5A5_5A5A_0F0F_F0F0);
    endtask

    task automatic test_timer_edges();
        settle_link();
        write_reg(REG_POLL_INTERVAL, 32'hFFFF);
        write_reg(REG_OFFLINE_TIMEOUT, 32'hFFFF);
        write_reg(REG_ABORT_MASK, '0);
        write_reg(REG_STATUS_TOPIC, 32'h7FF);
        write_reg(REG_STATUS_LENGTH, 32'd8);
        // past the last register: must change nothing
        write_reg(REG_SPARE, '1);
        // full status word passes an empty mask; timeout reloads at its maximum
        push_word(ACT_MESSAGE, 11'h7FF, 4'd8, '1, '0);
        push_word(ACT_MESSAGE, 11'h7FF, 4'd0, '1, '0);
        push_word(ACT_MESSAGE, '0, 4'd8, '1, '0);
    endtask

    task automatic test_idle_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            settle_link();
            write_reg(REG_POLL_INTERVAL, $urandom_range(6, 1));
            write_reg(REG_OFFLINE_TIMEOUT, $urandom_range(10, 1));
            write_reg(REG_ABORT_MASK, (phase < 2) ? 0 : $urandom_range(65535, 0));
            write_reg(REG_STATUS_TOPIC, (phase == 0) ? 0 :
                                        (phase == 1) ? 2047 : $urandom_range(2047, 0));
            write_reg(REG_STATUS_LENGTH, (phase == 0) ? 1 :
                                         (phase == 1) ? 8 : $urandom_range(8, 1));
            repeat (120) push_random_word(1'b0);
        end
    endtask

    // Leave idle for good: board abort on most seeds, liftoff on the rest
    task automatic test_final_mode();
        logic [CFG_W-1:0] trip_mask;
        logic [CFG_W-1:0] word;
        bit to_end;
        to_end = ($urandom_range(3, 0) == 0);
        settle_link();
        trip_mask = CFG_W'($urandom_range(65535, 1));
        write_reg(REG_ABORT_MASK, PDATA_W'(trip_mask));
        repeat (3)
            push_word(ACT_MESSAGE, cfg_topic, cfg_len, CFG_W'($urandom) & ~trip_mask,
                      {$urandom, $urandom});
        if (to_end)
            push_word(ACT_LIFTOFF, TOPIC_W'($urandom), cfg_len, '0, '0);
        else
        begin
            word = CFG_W'($urandom) & trip_mask;
            if (word == '0)
                word = trip_mask;
            push_word(ACT_MESSAGE, cfg_topic, cfg_len, word, {$urandom, $urandom});
        end
        repeat (200) push_random_word(1'b1);
        settle_link();
        write_reg(REG_POLL_INTERVAL, 32'hFFFF);
        write_reg(REG_OFFLINE_TIMEOUT, 32'd1);
        write_reg(REG_ABORT_MASK, 32'hFFFF);
        write_reg(REG_STATUS_TOPIC, $urandom_range(2047, 0));
        write_reg(REG_STATUS_LENGTH, $urandom_range(8, 1));
        repeat (100) push_random_word(1'b1);
        // run the tail at full rate on both sides
        bursts_on = 1'b0;
        repeat (100) push_random_word(1'b1);
    endtask

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (report_q.size() == 0)
            begin
                $error("result word with no prediction pending");
                fault_count++;
            end
            else
            begin
                want = report_q.pop_front();
                check_field("send_kind", 64'(want.send_kind), 64'(send_kind));
                check_field("send_payload", want.send_payload, send_payload);
                check_field("offline_alarm", 64'(want.offline_alarm), 64'(offline_alarm));
                check_field("aborted_alarm", 64'(want.aborted_alarm), 64'(aborted_alarm));
                check_field("mode", 64'(want.mode), 64'(mode));
                check_field("sent_total", 64'(want.sent_total), 64'(sent_total));
                check_field("received_total", 64'(want.received_total),
                            64'(received_total));
                check_field("flags", 64'(want.flags), 64'(flags));
            end
        end
        // stall the result side in short random bursts
        if (ready_hold > 0)
        begin
            result_ready <= 1'b0;
            ready_hold--;
        end
        else if (bursts_on && $urandom_range(4, 0) == 0)
        begin
            result_ready <= 1'b0;
            ready_hold = $urandom_range(3, 0);
        end
        else
            result_ready <= 1'b1;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        fault_count = 0;
        ready_hold  = 0;
        bursts_on   = 1'b1;
        cfg_poll    = POLL_INTERVAL_RST;
        cfg_timeout = OFFLINE_TIMEOUT_RST;
        cfg_mask    = ABORT_MASK_RST;
        cfg_topic   = STATUS_TOPIC_RST;
        cfg_len     = STATUS_LENGTH_RST;
        sup_mode    = MODE_OUT_IDLE;
        poll_left   = 1;
        off_left    = OFFLINE_TIMEOUT_RST;
        off_armed   = 1'b1;
        sent_cnt    = '0;
        recv_cnt    = '0;
        sticky      = '0;

        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        item_valid      <= 1'b0;
        action          <= ACT_TICK;
        msg_topic       <= '0;
        msg_length      <= '0;
        msg_status_word <= '0;
        launch_code     <= '0;
        result_ready    <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_polling();
        test_command_requests();
        test_timer_edges();
        test_idle_traffic();
        test_final_mode();

        settle_link();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
